// File: sv/bhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the binary heap priority queue.
// No dependencies; every other file but bhpq_ram.sv refers to it by scoped names.
package bhpq_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_BITS_DEF  = 32;
  localparam int KEY_IN_W      = 32;
  localparam int ENTRY_COUNT_W = 11;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_MIN_FIRST   = 1'b0,
    CFG_SIGNED_KEYS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic min_first;
    logic signed_keys;
  } cfg_t;

  typedef struct packed {
    logic [KEY_IN_W-1:0]      popped_key;
    status_t                  status;
    logic [KEY_IN_W-1:0]      top_key;
    logic                     top_valid;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

// File: sv/bhpq_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and config write.
// Depends on bhpq_pkg for field types and widths.
interface bhpq_req_if;
  logic                          valid;
  logic                          ready;
  bhpq_pkg::req_type_t           req_type;
  logic [bhpq_pkg::KEY_IN_W-1:0] key_in;

  modport source (output valid, output req_type, output key_in, input ready);
  modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

interface bhpq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [bhpq_pkg::KEY_IN_W-1:0]      popped_key;
  bhpq_pkg::status_t                  status;
  logic [bhpq_pkg::KEY_IN_W-1:0]      top_key;
  logic                               top_valid;
  logic [bhpq_pkg::ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output popped_key, output status, output top_key,
                  output top_valid, output entry_count, input ready);
  modport sink   (input valid, input popped_key, input status, input top_key,
                  input top_valid, input entry_count, output ready);
endinterface

interface bhpq_cfg_if;
  logic                valid;
  logic                ready;
  bhpq_pkg::cfg_idx_t  index;
  logic                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/bhpq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bhpq_ctrl.sv
`timescale 1ns / 1ps
// Heap sequencer: push sift-up and pop sift-down over the heap RAM, root cache.
// Depends on bhpq_pkg; drives the ports of one bhpq_ram instance.
module bhpq_ctrl #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bhpq_pkg::cfg_t                cfg,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bhpq_pkg::req_type_t           req_type,
  input  logic [bhpq_pkg::KEY_IN_W-1:0] key_in,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bhpq_pkg::rsp_t                res,
  output logic                          wr_en,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr,
  output logic [KEY_BITS-1:0]           wr_data,
  output logic                          rd_en,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr,
  input  logic [KEY_BITS-1:0]           rd_data
);

  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int EXT_W     = ADDR_W + 2;
  localparam int KEY_OUT_W = bhpq_pkg::KEY_IN_W;
  localparam int OUT_CNT_W = bhpq_pkg::ENTRY_COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_LAST_RD,
    S_LAST_WAIT,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_FIN,
    S_DONE
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [ADDR_W-1:0]     pos;
  logic [KEY_BITS-1:0]   key;
  logic [KEY_BITS-1:0]   ldata;
  logic [KEY_BITS-1:0]   root;
  logic [KEY_BITS-1:0]   popped;
  bhpq_pkg::status_t     status;

  // true when a ranks strictly above b under the current ordering
  function automatic logic above(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b,
                                 input logic min_first, input logic signed_keys);
    logic [KEY_BITS-1:0] x;
    logic [KEY_BITS-1:0] y;
    x = a;
    y = b;
    if (signed_keys) begin
      x[KEY_BITS-1] = ~x[KEY_BITS-1];
      y[KEY_BITS-1] = ~y[KEY_BITS-1];
    end
    return min_first ? (x < y) : (x > y);
  endfunction

  logic [ADDR_W-1:0] pos_m1;
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W-1:0] lchild;
  logic [ADDR_W-1:0] rchild;
  logic [EXT_W-1:0]  rchild_ext;
  logic              r_in;
  logic [CNT_W-1:0]  half;
  logic              up_move;
  logic              l_up;
  logic              r_up;
  logic [KEY_BITS-1:0] best_data;
  logic [ADDR_W-1:0] new_pos;
  logic [ADDR_W-1:0] new_lchild;
  logic              more;

  always_comb begin
    pos_m1     = pos - ADDR_W'(1);
    parent     = pos_m1 >> 1;
    lchild     = ADDR_W'({pos, 1'b1});
    rchild     = lchild + ADDR_W'(1);
    rchild_ext = EXT_W'({pos, 1'b1}) + EXT_W'(1);
    r_in       = rchild_ext < EXT_W'(count);
    half       = count >> 1;
    up_move    = above(key, rd_data, cfg.min_first, cfg.signed_keys);
    l_up       = above(ldata, key, cfg.min_first, cfg.signed_keys);
    best_data  = l_up ? ldata : key;
    r_up       = r_in && above(rd_data, best_data, cfg.min_first, cfg.signed_keys);
    new_pos    = r_up ? rchild : lchild;
    new_lchild = ADDR_W'({new_pos, 1'b1});
    more       = CNT_W'(new_pos) < half;
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = key;
    rd_en   = 1'b0;
    rd_addr = pos;
    unique case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_move ? rd_data : key;
      end
      S_LAST_RD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(count);
      end
      S_LAST_WAIT: begin
        if (half == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = rd_data;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(1);
        end
      end
      S_DN_RDR: begin
        rd_en   = 1'b1;
        rd_addr = rchild;
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = r_up ? rd_data : (l_up ? ldata : key);
        if ((r_up || l_up) && more) begin
          rd_en   = 1'b1;
          rd_addr = new_lchild;
        end
      end
      S_DN_FIN: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            status <= bhpq_pkg::ST_OK;
            popped <= '0;
            if (req_type == bhpq_pkg::REQ_PUSH) begin
              if (count == CNT_W'(CAPACITY)) begin
                status <= bhpq_pkg::ST_FULL;
                state  <= S_DONE;
              end else begin
                key   <= KEY_BITS'(key_in);
                pos   <= count[ADDR_W-1:0];
                count <= count + CNT_W'(1);
                state <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                status <= bhpq_pkg::ST_EMPTY;
                state  <= S_DONE;
              end else begin
                popped <= root;
                count  <= count - CNT_W'(1);
                state  <= (count == CNT_W'(1)) ? S_DONE : S_LAST_RD;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_LAST_RD: begin
          state <= S_LAST_WAIT;
        end
        S_LAST_WAIT: begin
          key   <= rd_data;
          pos   <= '0;
          state <= (half == '0) ? S_DONE : S_DN_RDR;
        end
        S_DN_RDR: begin
          ldata <= rd_data;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (r_up || l_up) begin
            pos   <= new_pos;
            state <= more ? S_DN_RDR : S_DN_FIN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // root shadow: follows every write to the top entry
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      root <= wr_data;
    end
  end

  assign req_ready       = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.popped_key  = KEY_OUT_W'(popped);
  assign res.status      = status;
  assign res.top_key     = (count != '0) ? KEY_OUT_W'(root) : '0;
  assign res.top_valid   = (count != '0);
  assign res.entry_count = OUT_CNT_W'(count);

endmodule

// File: sv/binary_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// Binary heap priority queue of CAPACITY keys of KEY_BITS bits, held in one
// simple dual-port RAM (bhpq_ram) and walked by the bhpq_ctrl sequencer; uses
// bhpq_pkg and the channel interfaces in bhpq_ifs.sv. One request is in work at
// a time and each yields one response item. A push moves the new key up and a
// pop moves the last entry down from the root, through at most log2 CAPACITY
// levels. The RAM has a single read port with a registered read, so each level
// going up is a read of the parent, then a compare and write, and each level
// going down is a read of the right child, then a compare, write and read of
// the next left child; a pop first fetches the last entry. Dropped pushes, pops
// on an empty heap and pops of the last entry go straight to the response.
// The response sits in an output register, so the next request is taken
// while it waits.
// min_first and signed_keys must only be written while the queue is idle.
module binary_heap_priority_queue_unit #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bhpq_req_if.sink   req,
  bhpq_rsp_if.source rsp,
  bhpq_cfg_if.sink   cfg
);

  localparam int ADDR_W = $clog2(CAPACITY);

  bhpq_pkg::cfg_t      cfg_regs;
  logic                res_valid;
  logic                res_ready;
  bhpq_pkg::rsp_t      res;
  bhpq_pkg::rsp_t      rsp_q;
  logic                rsp_valid;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [KEY_BITS-1:0] rd_data;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bhpq_pkg::CFG_MIN_FIRST:   cfg_regs.min_first   <= cfg.data;
        bhpq_pkg::CFG_SIGNED_KEYS: cfg_regs.signed_keys <= cfg.data;
      endcase
    end
  end

  bhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .key_in    (req.key_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bhpq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // response output register
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.popped_key  = rsp_q.popped_key;
  assign rsp.status      = rsp_q.status;
  assign rsp.top_key     = rsp_q.top_key;
  assign rsp.top_valid   = rsp_q.top_valid;
  assign rsp.entry_count = rsp_q.entry_count;

endmodule

// File: verif/binary_heap_priority_queue_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for binary_heap_priority_queue_unit: a directed table, then random push/pop
// traffic in three more order settings, scored against an in-bench heap. Needs bhpq_pkg, bhpq_ifs.
module binary_heap_priority_queue_unit_test;

  localparam int HEAP_DEPTH  = bhpq_pkg::CAPACITY_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400_000;

  typedef struct {
    bhpq_pkg::req_type_t op;
    logic [31:0]         key;
    bit                  pinned;   // want holds the typed-in result
    bhpq_pkg::rsp_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_rsp = 1'b0;
  int   src_idle_pct;
  int   rcv_idle_pct;
  int   cycles = 0;
  int   fail_count = 0;
  int   n_req = 0, n_rsp = 0, n_full = 0, n_empty = 0;
  event hold_start;

  // shadow heap and order setting
  logic [31:0] heap_mdl [HEAP_DEPTH];
  int          heap_fill = 0;
  logic        min_first = 1'b0;
  logic        signed_keys = 1'b0;

  bhpq_pkg::rsp_t rsp_due [$];
  row_t           pin_q [$];

  row_t dir_rows [22] = '{
    '{bhpq_pkg::REQ_POP,  32'h0000_0000, 1'b1,
      '{32'h0, bhpq_pkg::ST_EMPTY, 32'h0, 1'b0, 11'd0}},
    '{bhpq_pkg::REQ_PUSH, 32'h0000_0000, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'h0, 1'b1, 11'd1}},
    '{bhpq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'hFFFF_FFFF, 1'b1, 11'd2}},
    '{bhpq_pkg::REQ_PUSH, 32'h8000_0000, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'hFFFF_FFFF, 1'b1, 11'd3}},
    '{bhpq_pkg::REQ_PUSH, 32'h7FFF_FFFF, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'hFFFF_FFFF, 1'b1, 11'd4}},
    '{bhpq_pkg::REQ_PUSH, 32'h0000_0001, 1'b0, '0},
    '{bhpq_pkg::REQ_PUSH, 32'h5A5A_5A5A, 1'b0, '0},
    '{bhpq_pkg::REQ_PUSH, 32'h5A5A_5A5A, 1'b0, '0},
    '{bhpq_pkg::REQ_PUSH, 32'hA5A5_A5A5, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, bhpq_pkg::ST_OK, 32'hA5A5_A5A5, 1'b1, 11'd7}},
    '{bhpq_pkg::REQ_POP,  32'hFFFF_FFFF, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'h0000_0000, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'h1234_5678, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'hFFFF_FFFF, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'h0000_0000, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'h8000_0000, 1'b0, '0},
    '{bhpq_pkg::REQ_POP,  32'h0000_0000, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'h0, 1'b0, 11'd0}},
    '{bhpq_pkg::REQ_POP,  32'hFFFF_FFFF, 1'b1,
      '{32'h0, bhpq_pkg::ST_EMPTY, 32'h0, 1'b0, 11'd0}},
    '{bhpq_pkg::REQ_PUSH, 32'h0000_0007, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'h7, 1'b1, 11'd1}},
    '{bhpq_pkg::REQ_POP,  32'hFFFF_FFFF, 1'b1,
      '{32'h7, bhpq_pkg::ST_OK, 32'h0, 1'b0, 11'd0}},
    '{bhpq_pkg::REQ_PUSH, 32'h8000_0000, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'h8000_0000, 1'b1, 11'd1}},
    '{bhpq_pkg::REQ_PUSH, 32'h7FFF_FFFF, 1'b1,
      '{32'h0, bhpq_pkg::ST_OK, 32'h8000_0000, 1'b1, 11'd2}}
  };

  bhpq_req_if req_ch ();
  bhpq_rsp_if rsp_ch ();
  bhpq_cfg_if cfg_ch ();

  binary_heap_priority_queue_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  function automatic bit outranks(logic [31:0] a, logic [31:0] b);
    if (signed_keys) begin
      a ^= 32'h8000_0000;
      b ^= 32'h8000_0000;
    end
    return min_first ? (a < b) : (a > b);
  endfunction

  // Applies one request to the shadow heap and returns the response it should produce.
  function automatic bhpq_pkg::rsp_t apply_req(bhpq_pkg::req_type_t op, logic [31:0] key);
    bhpq_pkg::rsp_t r;
    int             pos, parent, lc, rc, best;
    logic [31:0]    tmp;
    r = '0;
    r.status = bhpq_pkg::ST_OK;
    if (op == bhpq_pkg::REQ_PUSH) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = bhpq_pkg::ST_FULL;
      end else begin
        pos = heap_fill;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!outranks(key, heap_mdl[parent])) break;
          heap_mdl[pos] = heap_mdl[parent];
          pos = parent;
        end
        heap_mdl[pos] = key;
        heap_fill++;
      end
    end else if (heap_fill == 0) begin
      r.status = bhpq_pkg::ST_EMPTY;
    end else begin
      r.popped_key = heap_mdl[0];
      heap_mdl[0] = heap_mdl[heap_fill - 1];
      heap_fill--;
      pos = 0;
      while (pos < heap_fill / 2) begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        best = pos;
        if (lc < heap_fill && outranks(heap_mdl[lc], heap_mdl[best])) best = lc;
        if (rc < heap_fill && outranks(heap_mdl[rc], heap_mdl[best])) best = rc;
        if (best == pos) break;
        tmp = heap_mdl[pos];
        heap_mdl[pos] = heap_mdl[best];
        heap_mdl[best] = tmp;
        pos = best;
      end
    end
    r.top_key = (heap_fill != 0) ? heap_mdl[0] : 32'h0;
    r.top_valid = (heap_fill != 0);
    r.entry_count = heap_fill[bhpq_pkg::ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Scoreboard: config writes, accepted requests, accepted responses.
  always @(posedge clk) begin : scoreboard
    bhpq_pkg::rsp_t due;
    row_t           pin;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == bhpq_pkg::CFG_MIN_FIRST) min_first = cfg_ch.data;
        else signed_keys = cfg_ch.data;
      end
      if (req_ch.valid && req_ch.ready) begin
        due = apply_req(req_ch.req_type, req_ch.key_in);
        if (pin_q.size() != 0) begin
          pin = pin_q.pop_front();
          if (pin.pinned) due = pin.want;
        end
        if (due.status == bhpq_pkg::ST_FULL) n_full++;
        if (due.status == bhpq_pkg::ST_EMPTY) n_empty++;
        n_req++;
        rsp_due.push_back(due);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_rsp++;
        if (rsp_due.size() == 0) begin
          $display("%0t: response with none expected, top_key %0h count %0d", $time,
                   rsp_ch.top_key, rsp_ch.entry_count);
          fail_count++;
        end else begin
          due = rsp_due.pop_front();
          cmp_field("popped_key", due.popped_key, rsp_ch.popped_key);
          cmp_field("status", due.status, rsp_ch.status);
          cmp_field("top_key", due.top_key, rsp_ch.top_key);
          cmp_field("top_valid", due.top_valid, rsp_ch.top_valid);
          cmp_field("entry_count", due.entry_count, rsp_ch.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (hold_rsp) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // long receiver stall, counted here
  initial forever begin
    @(hold_start);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d responses outstanding", $time, rsp_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drive_req(bhpq_pkg::req_type_t op, logic [31:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key_in <= key;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // drops valid and waits on the clock first so the scoreboard has logged the last accepted request
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic drain_heap();
    int remaining;
    wait_idle();
    remaining = heap_fill;
    repeat (remaining) drive_req(bhpq_pkg::REQ_POP, $urandom);
    wait_idle();
  endtask

  task automatic set_order(logic mf, logic sk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= bhpq_pkg::CFG_MIN_FIRST;
    cfg_ch.data <= mf;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= bhpq_pkg::CFG_SIGNED_KEYS;
    cfg_ch.data <= sk;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // extremes and small keys of both signs are frequent, so ties and sign flips show up
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4, 5: return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_mixed(int n, int push_pct);
    repeat (n) begin
      if ($urandom_range(99) < push_pct) drive_req(bhpq_pkg::REQ_PUSH, pick_key());
      else drive_req(bhpq_pkg::REQ_POP, $urandom);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= bhpq_pkg::REQ_PUSH;
    req_ch.key_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= bhpq_pkg::CFG_MIN_FIRST;
    cfg_ch.data <= 1'b0;
    src_idle_pct = 8;
    rcv_idle_pct <= 72;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table under the reset order (largest first, unsigned)
    foreach (dir_rows[i]) begin
      pin_q.push_back(dir_rows[i]);
      drive_req(dir_rows[i].op, dir_rows[i].key);
    end

    // smallest first, unsigned; receiver mostly stalled, plus one long hold
    drain_heap();
    set_order(1'b1, 1'b0);
    run_mixed(50, 55);
    -> hold_start;
    run_mixed(50, 55);

    // largest first, signed; sender mostly idle
    drain_heap();
    src_idle_pct = 72;
    rcv_idle_pct <= 8;
    set_order(1'b0, 1'b1);
    run_mixed(80, 60);

    // smallest first, signed; no idling, fill past capacity
    drain_heap();
    src_idle_pct = 0;
    rcv_idle_pct <= 0;
    set_order(1'b1, 1'b1);
    repeat (HEAP_DEPTH + 6) drive_req(bhpq_pkg::REQ_PUSH, pick_key());
    run_mixed(40, 60);

    wait_idle();
    repeat (64) @(posedge clk);
    $display("Run covered %0d requests and %0d responses over all four order settings,",
             n_req, n_rsp);
    $display("with %0d pushes dropped on a full heap and %0d pops on an empty one.",
             n_full, n_empty);
    if (fail_count == 0 && rsp_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
